>>> hw/rtl/fcmc_pkg.sv
// ----------------------------------------------------------------------------
// fcmc_pkg
// Shared constants and types of the FIFO cache miss classifier.
// ----------------------------------------------------------------------------
package fcmc_pkg;

    localparam int MAX_ENTRIES = 32;
    localparam int ADDR_BITS   = 16;
    localparam int COUNT_BITS  = 32;
    localparam int IDX_BITS    = $clog2(MAX_ENTRIES);
    localparam int SIZE_BITS   = 6;
    localparam int SEEN_WIDTH  = 32;
    localparam int SEEN_SEL    = $clog2(SEEN_WIDTH);
    localparam int SEEN_WORDS  = (2 ** ADDR_BITS) / SEEN_WIDTH;
    localparam int SEEN_IBITS  = $clog2(SEEN_WORDS);
    localparam int IN_BITS     = 16;
    localparam int OUT_BITS    = 104;

    localparam logic [SIZE_BITS-1:0] SIZE_RESET = SIZE_BITS'(32);

    localparam logic [1:0] KIND_HIT        = 2'd0;
    localparam logic [1:0] KIND_COMPULSORY = 2'd1;
    localparam logic [1:0] KIND_CAPACITY   = 2'd2;

    typedef struct packed {
        logic clr_step;
        logic load;
        logic scan_step;
        logic commit;
    } t_cmd;

    typedef struct packed {
        logic clr_last;
        logic scan_done;
        logic out_free;
    } t_stat;

endpackage

>>> hw/rtl/fcmc_ctrl.sv
// ----------------------------------------------------------------------------
// fcmc_ctrl
// Sequencer: bitmap clear after reset, then accept, tag scan and commit.
// ----------------------------------------------------------------------------
module fcmc_ctrl
    import fcmc_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_in_valid,
    output logic  o_in_ready,
    input  t_stat i_stat,
    output t_cmd  o_cmd
);

    localparam logic [1:0] ST_CLEAR  = 2'd0;
    localparam logic [1:0] ST_IDLE   = 2'd1;
    localparam logic [1:0] ST_SCAN   = 2'd2;
    localparam logic [1:0] ST_FINISH = 2'd3;

    logic [1:0] r_state;
    logic [1:0] n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        case (r_state)
            ST_CLEAR: begin
                o_cmd.clr_step = 1'b1;
                if (i_stat.clr_last) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = ST_SCAN;
                end
            end
            ST_SCAN: begin
                o_cmd.scan_step = 1'b1;
                if (i_stat.scan_done) begin
                    n_state = ST_FINISH;
                end
            end
            ST_FINISH: begin
                if (i_stat.out_free) begin
                    o_cmd.commit = 1'b1;
                    n_state      = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_CLEAR;
            end
        endcase
    end

endmodule

>>> hw/rtl/fcmc_dp.sv
// ----------------------------------------------------------------------------
// fcmc_dp
// Datapath: tag store, visited bitmap, FIFO pointers, counters, output reg.
// ----------------------------------------------------------------------------
module fcmc_dp
    import fcmc_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_wen,
    input  logic [SIZE_BITS-1:0] i_cfg_wdata,
    input  logic [IN_BITS-1:0]   i_in_data,
    input  t_cmd                 i_cmd,
    output t_stat                o_stat,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output logic [OUT_BITS-1:0]  o_out_data
);

    logic [ADDR_BITS-1:0]  r_tag_mem [MAX_ENTRIES];
    logic [SEEN_WIDTH-1:0] r_seen_mem [SEEN_WORDS];

    logic [SIZE_BITS-1:0]  r_cfg_size;
    logic [SIZE_BITS-1:0]  r_fill;
    logic [IDX_BITS-1:0]   r_oldest;
    logic [SEEN_IBITS-1:0] r_clr_idx;
    logic [ADDR_BITS-1:0]  r_addr;
    logic [IDX_BITS-1:0]   r_idx;
    logic [ADDR_BITS-1:0]  r_tag_q;
    logic [SEEN_WIDTH-1:0] r_seen_q;
    logic                  r_hit;
    logic [COUNT_BITS-1:0] r_acc;
    logic [COUNT_BITS-1:0] r_comp;
    logic [COUNT_BITS-1:0] r_cap;
    logic                  r_out_valid;
    logic [OUT_BITS-1:0]   r_out_data;

    logic [SIZE_BITS-1:0]  size_eff;
    logic                  entry_valid;
    logic                  cur_hit;
    logic [SIZE_BITS-1:0]  idx_next;
    logic [IDX_BITS-1:0]   tag_rd_idx;
    logic [SEEN_IBITS-1:0] seen_rd_idx;
    logic [SEEN_IBITS-1:0] word_idx;
    logic [SEEN_SEL-1:0]   bit_sel;
    logic                  seen_bit;
    logic                  filling;
    logic [IDX_BITS-1:0]   wr_slot;
    logic [IDX_BITS-1:0]   oldest_next;
    logic [1:0]            kind;
    logic [COUNT_BITS-1:0] n_acc;
    logic [COUNT_BITS-1:0] n_comp;
    logic [COUNT_BITS-1:0] n_cap;

    always_comb begin
        size_eff = r_cfg_size;
        if (r_cfg_size == '0) begin
            size_eff = SIZE_BITS'(1);
        end else if (r_cfg_size > SIZE_BITS'(MAX_ENTRIES)) begin
            size_eff = SIZE_BITS'(MAX_ENTRIES);
        end
    end

    assign word_idx    = r_addr[ADDR_BITS-1:SEEN_SEL];
    assign bit_sel     = r_addr[SEEN_SEL-1:0];
    assign seen_bit    = r_seen_q[bit_sel];
    assign idx_next    = SIZE_BITS'(r_idx) + SIZE_BITS'(1);
    assign entry_valid = SIZE_BITS'(r_idx) < r_fill;
    assign cur_hit     = entry_valid && (r_tag_q == r_addr);
    assign tag_rd_idx  = i_cmd.load ? '0 : idx_next[IDX_BITS-1:0];
    assign seen_rd_idx = i_cmd.load ? i_in_data[ADDR_BITS-1:SEEN_SEL] : word_idx;

    assign filling     = r_fill < size_eff;
    assign wr_slot     = filling ? r_fill[IDX_BITS-1:0] : r_oldest;
    assign oldest_next = (SIZE_BITS'(r_oldest) + SIZE_BITS'(1) == size_eff)
                       ? '0 : r_oldest + IDX_BITS'(1);

    assign kind   = r_hit ? KIND_HIT : (seen_bit ? KIND_CAPACITY : KIND_COMPULSORY);
    assign n_acc  = (&r_acc) ? r_acc : r_acc + COUNT_BITS'(1);
    assign n_comp = (kind == KIND_COMPULSORY && !(&r_comp)) ? r_comp + COUNT_BITS'(1)
                                                            : r_comp;
    assign n_cap  = (kind == KIND_CAPACITY && !(&r_cap)) ? r_cap + COUNT_BITS'(1) : r_cap;

    assign o_stat.clr_last  = &r_clr_idx;
    assign o_stat.scan_done = !entry_valid || cur_hit || (idx_next == r_fill);
    assign o_stat.out_free  = !r_out_valid || i_out_ready;

    // tag store and bitmap
    always_ff @(posedge i_clk) begin
        r_tag_q  <= r_tag_mem[tag_rd_idx];
        r_seen_q <= r_seen_mem[seen_rd_idx];
        if (i_cmd.commit && !r_hit) begin
            r_tag_mem[wr_slot] <= r_addr;
        end
        if (i_cmd.clr_step) begin
            r_seen_mem[r_clr_idx] <= '0;
        end else if (i_cmd.commit) begin
            r_seen_mem[word_idx] <= r_seen_q | (SEEN_WIDTH'(1) << bit_sel);
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_addr <= i_in_data[ADDR_BITS-1:0];
            r_idx  <= '0;
        end else if (i_cmd.scan_step) begin
            if (o_stat.scan_done) begin
                r_hit <= cur_hit;
            end else begin
                r_idx <= idx_next[IDX_BITS-1:0];
            end
        end
        if (i_cmd.commit) begin
            r_out_data <= {5'd0, n_cap, n_comp, n_acc, kind, r_hit};
        end
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_size  <= SIZE_RESET;
            r_fill      <= '0;
            r_oldest    <= '0;
            r_clr_idx   <= '0;
            r_acc       <= '0;
            r_comp      <= '0;
            r_cap       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.clr_step) begin
                r_clr_idx <= r_clr_idx + SEEN_IBITS'(1);
            end
            if (i_cfg_wen) begin
                r_cfg_size <= i_cfg_wdata;
                r_fill     <= '0;
                r_oldest   <= '0;
            end else if (i_cmd.commit && !r_hit) begin
                if (filling) begin
                    r_fill <= r_fill + SIZE_BITS'(1);
                end else begin
                    r_oldest <= oldest_next;
                end
            end
            if (i_cmd.commit) begin
                r_acc       <= n_acc;
                r_comp      <= n_comp;
                r_cap       <= n_cap;
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

endmodule

>>> hw/rtl/fifo_cache_miss_classifier.sv
// ----------------------------------------------------------------------------
// fifo_cache_miss_classifier
// Fully associative cache with FIFO replacement and miss classification.
// ----------------------------------------------------------------------------
// After reset the visited bitmap is cleared one 32-bit row per cycle, all 2048
// rows, with s_axis_tready low; configuration writes are taken meanwhile.
// Each access then compares filled entries up to and including a matching
// one (at most 32), and is committed only once the previous result has left
// the output register; the tag store has one read port and is searched one
// tag per cycle. A result waits in the output register while the next
// request is accepted. Writing entries_in_use empties the cache but keeps
// the bitmap and the counts.
module fifo_cache_miss_classifier
    import fcmc_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_wen,
    input  logic [SIZE_BITS-1:0] i_cfg_wdata,
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    input  logic [IN_BITS-1:0]   s_axis_tdata,   // block_address
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    output logic [OUT_BITS-1:0]  m_axis_tdata    // is_hit, miss_kind, access_count,
                                                 // compulsory_count, capacity_count
);

    t_cmd  cmd;
    t_stat stat;

    fcmc_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .o_in_ready (s_axis_tready),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    fcmc_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_wen   (i_cfg_wen),
        .i_cfg_wdata (i_cfg_wdata),
        .i_in_data   (s_axis_tdata),
        .i_cmd       (cmd),
        .o_stat      (stat),
        .o_out_valid (m_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .o_out_data  (m_axis_tdata)
    );

endmodule

>>> hw/rtl/fcmc_chk.sv
// ----------------------------------------------------------------------------
// fcmc_chk
// Port-level checks of the FIFO cache miss classifier.
// ----------------------------------------------------------------------------
module fcmc_chk
    import fcmc_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                s_axis_tvalid,
    input  logic                s_axis_tready,
    input  logic                m_axis_tvalid,
    input  logic                m_axis_tready,
    input  logic [OUT_BITS-1:0] m_axis_tdata
);

    a_rst_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid && !s_axis_tready)
        else $error("output valid or input ready after reset");

    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("request accepted while previous one in progress");

    a_kind_match: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (m_axis_tdata[0] == (m_axis_tdata[2:1] == KIND_HIT))
                          && (m_axis_tdata[2:1] != 2'd3))
        else $error("hit flag and miss kind disagree");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("stalled result changed");

endmodule

bind fifo_cache_miss_classifier fcmc_chk u_fcmc_chk (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);
